/* design/srct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared widths, token codes and the token and bundle types that pass from
// the scanner through the queue to the output stage.
// ----------------------------------------------------------------------------
package srct_pkg;

  localparam int OffsetBits = 16;
  localparam int MaxTok     = 3;
  localparam int TokIdxW    = $clog2(MaxTok);
  localparam int TokCntW    = $clog2(MaxTok + 1);
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    KIND_ERR   = 3'd0,
    KIND_INT   = 3'd1,
    KIND_FLOAT = 3'd2,
    KIND_OP    = 3'd3,
    KIND_KW    = 3'd4,
    KIND_ID    = 3'd5
  } kind_e;

  localparam logic [2:0] BASE_DEC = 3'd0;
  localparam logic [2:0] BASE_HEX = 3'd1;
  localparam logic [2:0] BASE_OCT = 3'd2;
  localparam logic [2:0] BASE_BIN = 3'd3;

  localparam logic [2:0] SUB_NONE   = 3'd0;
  localparam logic [2:0] SUB_DEFINE = 3'd0;
  localparam logic [2:0] SUB_DSLASH = 3'd1;
  localparam logic [2:0] SUB_ASSIGN = 3'd2;
  localparam logic [2:0] SUB_PLUS   = 3'd3;
  localparam logic [2:0] SUB_MINUS  = 3'd4;
  localparam logic [2:0] SUB_STAR   = 3'd5;
  localparam logic [2:0] SUB_SLASH  = 3'd6;
  localparam logic [2:0] SUB_EQUAL  = 3'd7;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  sub;
    logic [15:0] start;
    logic [15:0] len;
  } token_t;

  typedef struct packed {
    token_t [MaxTok-1:0] tok;
    logic [TokCntW-1:0]  cnt;
  } bundle_t;

endpackage

/* design/srct_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer scanner
// Accepts one byte per cycle unless the queue is full, advances the scan mode
// and gathers the tokens the byte completes into one bundle for the queue.
// ----------------------------------------------------------------------------
module srct_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            char_code_i,
  input  logic                  last_char_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output srct_pkg::bundle_t     q_data_o
);

  typedef logic [srct_pkg::OffsetBits-1:0] offs_t;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_ZERO   = 4'd1,
    MODE_DEC    = 4'd2,
    MODE_FLOAT  = 4'd3,
    MODE_HEX    = 4'd4,
    MODE_OCT    = 4'd5,
    MODE_BIN    = 4'd6,
    MODE_IDENT  = 4'd7,
    MODE_SLASH  = 4'd8,
    MODE_COLON1 = 4'd9,
    MODE_COLON2 = 4'd10
  } mode_e;

  typedef struct packed {
    logic [1:0]       n;
    srct_pkg::token_t a;
    srct_pkg::token_t b;
  } flush_t;

  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_I    = 2'd1;
  localparam logic [1:0] KW_IF   = 2'd2;

  localparam offs_t LEN_ONE   = offs_t'(1);
  localparam offs_t LEN_TWO   = offs_t'(2);
  localparam offs_t LEN_THREE = offs_t'(3);
  localparam offs_t LEN_MAX   = '1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_LC_O  = 8'h6F;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  function automatic logic is_dec_char(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dec_char(c) || ((c >= CH_LC_A) && (c <= CH_LC_F));
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic is_bin(logic [7:0] c);
    return (c == CH_ZERO) || (c == CH_ONE);
  endfunction

  function automatic logic is_idstart(logic [7:0] c);
    return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
           (c == CH_USCORE);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic offs_t grow(offs_t len);
    return (len == LEN_MAX) ? len : len + LEN_ONE;
  endfunction

  function automatic srct_pkg::token_t mk_tok(srct_pkg::kind_e k, logic [2:0] s,
                                              offs_t st, offs_t ln);
    srct_pkg::token_t t;
    t.kind  = k;
    t.sub   = s;
    t.start = 16'(st);
    t.len   = (32'(ln) > 32'h0000_FFFF) ? 16'hFFFF : 16'(ln);
    return t;
  endfunction

  function automatic flush_t flush_f(mode_e m, offs_t st, offs_t ln, logic [1:0] kw);
    flush_t f;
    f = '0;
    case (m)
      MODE_ZERO, MODE_DEC: begin
        f.n = 2'd1;
        f.a = mk_tok(srct_pkg::KIND_INT, srct_pkg::BASE_DEC, st, ln);
      end
      MODE_FLOAT: begin
        f.n = 2'd1;
        f.a = mk_tok(srct_pkg::KIND_FLOAT, srct_pkg::SUB_NONE, st, ln);
      end
      MODE_HEX: begin
        f.n = 2'd1;
        f.a = mk_tok(srct_pkg::KIND_INT, srct_pkg::BASE_HEX, st, ln);
      end
      MODE_OCT: begin
        f.n = 2'd1;
        f.a = mk_tok(srct_pkg::KIND_INT, srct_pkg::BASE_OCT, st, ln);
      end
      MODE_BIN: begin
        f.n = 2'd1;
        f.a = mk_tok(srct_pkg::KIND_INT, srct_pkg::BASE_BIN, st, ln);
      end
      MODE_IDENT: begin
        f.n = 2'd1;
        if ((kw == KW_IF) && (ln == LEN_TWO)) begin
          f.a = mk_tok(srct_pkg::KIND_KW, srct_pkg::SUB_NONE, st, ln);
        end else begin
          f.a = mk_tok(srct_pkg::KIND_ID, srct_pkg::SUB_NONE, st, ln);
        end
      end
      MODE_SLASH: begin
        f.n = 2'd1;
        f.a = mk_tok(srct_pkg::KIND_OP, srct_pkg::SUB_SLASH, st, LEN_ONE);
      end
      MODE_COLON1: begin
        f.n = 2'd1;
        f.a = mk_tok(srct_pkg::KIND_ERR, srct_pkg::SUB_NONE, st, LEN_ONE);
      end
      MODE_COLON2: begin
        f.n = 2'd2;
        f.a = mk_tok(srct_pkg::KIND_ERR, srct_pkg::SUB_NONE, st, LEN_ONE);
        f.b = mk_tok(srct_pkg::KIND_ERR, srct_pkg::SUB_NONE, st + LEN_ONE, LEN_ONE);
      end
      default: begin
        f.n = 2'd0;
      end
    endcase
    return f;
  endfunction

  mode_e      mode_q, mode_d;
  offs_t      start_q, start_d;
  offs_t      len_q, len_d;
  offs_t      pos_q, pos_d;
  logic [1:0] kw_q, kw_d;

  srct_pkg::token_t [srct_pkg::MaxTok-1:0] tok_v;
  logic [srct_pkg::TokCntW-1:0]            n_v;
  logic                                    brk_v;
  flush_t                                  fl_v;
  flush_t                                  fe_v;
  logic                                    accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    len_d   = len_q;
    kw_d    = kw_q;
    tok_v   = '0;
    n_v     = '0;
    brk_v   = 1'b0;

    case (mode_q)
      MODE_ZERO: begin
        if (char_code_i == CH_LC_X) begin
          mode_d = MODE_HEX;
          len_d  = grow(len_q);
        end else if (char_code_i == CH_LC_O) begin
          mode_d = MODE_OCT;
          len_d  = grow(len_q);
        end else if (char_code_i == CH_LC_B) begin
          mode_d = MODE_BIN;
          len_d  = grow(len_q);
        end else if (is_dec_char(char_code_i)) begin
          mode_d = MODE_DEC;
          len_d  = grow(len_q);
        end else if (char_code_i == CH_DOT) begin
          mode_d = MODE_FLOAT;
          len_d  = grow(len_q);
        end else begin
          brk_v = 1'b1;
        end
      end
      MODE_DEC: begin
        if (is_dec_char(char_code_i)) begin
          len_d = grow(len_q);
        end else if (char_code_i == CH_DOT) begin
          mode_d = MODE_FLOAT;
          len_d  = grow(len_q);
        end else begin
          brk_v = 1'b1;
        end
      end
      MODE_FLOAT: begin
        if (is_dec_char(char_code_i)) len_d = grow(len_q);
        else brk_v = 1'b1;
      end
      MODE_HEX: begin
        if (is_hex(char_code_i)) len_d = grow(len_q);
        else brk_v = 1'b1;
      end
      MODE_OCT: begin
        if (is_oct(char_code_i)) len_d = grow(len_q);
        else brk_v = 1'b1;
      end
      MODE_BIN: begin
        if (is_bin(char_code_i)) len_d = grow(len_q);
        else brk_v = 1'b1;
      end
      MODE_IDENT: begin
        if (is_idstart(char_code_i) || is_dec_char(char_code_i)) begin
          kw_d  = ((kw_q == KW_I) && (char_code_i == CH_LC_F)) ? KW_IF : KW_NONE;
          len_d = grow(len_q);
        end else begin
          brk_v = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (char_code_i == CH_SLASH) begin
          tok_v[n_v] = mk_tok(srct_pkg::KIND_OP, srct_pkg::SUB_DSLASH, start_q, LEN_TWO);
          n_v        = n_v + 1'b1;
          mode_d     = MODE_IDLE;
        end else begin
          brk_v = 1'b1;
        end
      end
      MODE_COLON1: begin
        if (char_code_i == CH_EQUAL) begin
          tok_v[n_v] = mk_tok(srct_pkg::KIND_OP, srct_pkg::SUB_ASSIGN, start_q, LEN_TWO);
          n_v        = n_v + 1'b1;
          mode_d     = MODE_IDLE;
        end else if (char_code_i == CH_COLON) begin
          mode_d = MODE_COLON2;
          len_d  = grow(len_q);
        end else begin
          brk_v = 1'b1;
        end
      end
      MODE_COLON2: begin
        if (char_code_i == CH_EQUAL) begin
          tok_v[n_v] = mk_tok(srct_pkg::KIND_OP, srct_pkg::SUB_DEFINE, start_q, LEN_THREE);
          n_v        = n_v + 1'b1;
          mode_d     = MODE_IDLE;
        end else if (char_code_i == CH_COLON) begin
          tok_v[n_v] = mk_tok(srct_pkg::KIND_ERR, srct_pkg::SUB_NONE, start_q, LEN_ONE);
          n_v        = n_v + 1'b1;
          start_d    = start_q + LEN_ONE;
        end else begin
          brk_v = 1'b1;
        end
      end
      default: begin
        brk_v = 1'b1;
      end
    endcase

    fl_v = flush_f(mode_q, start_q, len_q, kw_q);
    if (brk_v) begin
      if (fl_v.n != 2'd0) begin
        tok_v[n_v] = fl_v.a;
        n_v        = n_v + 1'b1;
      end
      if (fl_v.n == 2'd2) begin
        tok_v[n_v] = fl_v.b;
        n_v        = n_v + 1'b1;
      end
      mode_d = MODE_IDLE;
      kw_d   = KW_NONE;
      if (is_space(char_code_i)) begin
        mode_d = MODE_IDLE;
      end else if (char_code_i == CH_ZERO) begin
        mode_d  = MODE_ZERO;
        start_d = pos_q;
        len_d   = LEN_ONE;
      end else if (is_dec_char(char_code_i)) begin
        mode_d  = MODE_DEC;
        start_d = pos_q;
        len_d   = LEN_ONE;
      end else if (is_idstart(char_code_i)) begin
        mode_d  = MODE_IDENT;
        start_d = pos_q;
        len_d   = LEN_ONE;
        kw_d    = (char_code_i == CH_LC_I) ? KW_I : KW_NONE;
      end else if (char_code_i == CH_COLON) begin
        mode_d  = MODE_COLON1;
        start_d = pos_q;
        len_d   = LEN_ONE;
      end else if (char_code_i == CH_SLASH) begin
        mode_d  = MODE_SLASH;
        start_d = pos_q;
        len_d   = LEN_ONE;
      end else if (char_code_i == CH_PLUS) begin
        tok_v[n_v] = mk_tok(srct_pkg::KIND_OP, srct_pkg::SUB_PLUS, pos_q, LEN_ONE);
        n_v        = n_v + 1'b1;
      end else if (char_code_i == CH_MINUS) begin
        tok_v[n_v] = mk_tok(srct_pkg::KIND_OP, srct_pkg::SUB_MINUS, pos_q, LEN_ONE);
        n_v        = n_v + 1'b1;
      end else if (char_code_i == CH_STAR) begin
        tok_v[n_v] = mk_tok(srct_pkg::KIND_OP, srct_pkg::SUB_STAR, pos_q, LEN_ONE);
        n_v        = n_v + 1'b1;
      end else if (char_code_i == CH_EQUAL) begin
        tok_v[n_v] = mk_tok(srct_pkg::KIND_OP, srct_pkg::SUB_EQUAL, pos_q, LEN_ONE);
        n_v        = n_v + 1'b1;
      end else begin
        tok_v[n_v] = mk_tok(srct_pkg::KIND_ERR, srct_pkg::SUB_NONE, pos_q, LEN_ONE);
        n_v        = n_v + 1'b1;
      end
    end

    fe_v = flush_f(mode_d, start_d, len_d, kw_d);
    if (last_char_i) begin
      if (fe_v.n != 2'd0) begin
        tok_v[n_v] = fe_v.a;
        n_v        = n_v + 1'b1;
      end
      if (fe_v.n == 2'd2) begin
        tok_v[n_v] = fe_v.b;
        n_v        = n_v + 1'b1;
      end
      mode_d = MODE_IDLE;
      kw_d   = KW_NONE;
      pos_d  = '0;
    end else begin
      pos_d = pos_q + LEN_ONE;
    end
  end

  assign q_push_o     = accept && (n_v != '0);
  assign q_data_o.tok = tok_v;
  assign q_data_o.cnt = n_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      kw_q    <= KW_NONE;
    end else if (accept) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      kw_q    <= kw_d;
    end
  end

endmodule

/* design/srct_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer bundle queue
// A short first-in first-out queue of token bundles between the scanner and
// the output stage, with the head shown directly from its registers.
// ----------------------------------------------------------------------------
module srct_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  srct_pkg::bundle_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output srct_pkg::bundle_t head_o
);

  srct_pkg::bundle_t                   mem_q [srct_pkg::QDepth];
  logic [srct_pkg::QPtrW-1:0]          wr_ptr_q;
  logic [srct_pkg::QPtrW-1:0]          rd_ptr_q;
  logic [srct_pkg::QCntW-1:0]          cnt_q;
  logic                                do_push;
  logic                                do_pop;

  assign full_o  = (cnt_q == srct_pkg::QCntW'(srct_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* design/srct_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer output stage
// Takes the bundle at the head of the queue apart into single tokens and
// presents them from an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module srct_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  srct_pkg::bundle_t q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srct_pkg::token_t  tok_o,
  output logic              last_o
);

  logic                         out_valid_q;
  srct_pkg::token_t             tok_q;
  logic                         last_q;
  logic [srct_pkg::TokIdxW-1:0] idx_q;
  logic                         load;
  logic                         is_last;

  assign load    = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign is_last = ((srct_pkg::TokCntW'(idx_q) + srct_pkg::TokCntW'(1)) == q_head_i.cnt);
  assign q_pop_o = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= q_head_i.tok[idx_q];
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign tok_o       = tok_q;
  assign last_o      = last_q;

endmodule

/* design/source_text_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer
// Splits a byte stream of source text into number, operator, keyword,
// identifier and error tokens, with offset and length for each token.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------------
//   input   | in_valid_i / in_stall_o    | char_code_i, last_char_i
//   output  | out_valid_o / out_stall_i  | token_kind_o, token_sub_o,
//           |                            | token_start_o, token_length_o,
//           |                            | last_of_run_o
//
// One byte is taken every cycle while the bundle queue has room. A token
// goes from the byte that completes it into a queue entry and then the
// output register, which gives one token per cycle unless the output is
// stalled, so bytes that end up to three tokens drain at that rate. Reset
// clears the scan state, empties the queue and clears the output valid flag.
// An output stall fills the four-entry queue before the input stalls.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [2:0]  token_sub_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  logic              q_push;
  srct_pkg::bundle_t q_data;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  srct_pkg::bundle_t q_head;
  srct_pkg::token_t  tok;

  srct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_data)
  );

  srct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  srct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tok_o       (tok),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o   = tok.kind;
  assign token_sub_o    = tok.sub;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.len;

endmodule

/* design/srct_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer checker
// Port-level checks on the token stream, bound to the top level.
// ----------------------------------------------------------------------------
module srct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  token_kind_o,
  input logic [15:0] token_length_o,
  input logic [15:0] token_start_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(token_start_o)))
    else $error("stalled item changed or vanished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == srct_pkg::KIND_ERR)) |-> (token_length_o == 16'd1))
    else $error("error token longer than one byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == srct_pkg::KIND_OP)) |->
    ((token_length_o == 16'd1) || (token_length_o == 16'd2) || (token_length_o == 16'd3)))
    else $error("operator token length out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == srct_pkg::KIND_KW)) |-> (token_length_o == 16'd2))
    else $error("keyword token with wrong length");

endmodule

bind source_text_tokenizer srct_checker u_srct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .token_kind_o   (token_kind_o),
  .token_length_o (token_length_o),
  .token_start_o  (token_start_o)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Feeds byte streams of source text into the tokenizer and checks every
// token that comes out against a scanner model kept in the testbench. The
// stimulus runs from hand-picked texts through random well-formed texts with
// noise, a long output hold-off, and a final stretch with both sides always
// ready.
// ----------------------------------------------------------------------------
module tb;
  import srct_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 150;
  localparam int MaxReported   = 10;

  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_I    = 2'd1;
  localparam logic [1:0] KW_IF   = 2'd2;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_ZERO, SCAN_DEC, SCAN_FLOAT, SCAN_HEX, SCAN_OCT, SCAN_BIN,
    SCAN_IDENT, SCAN_SLASH, SCAN_COLON1, SCAN_COLON2
  } scan_e;

  typedef struct packed {
    token_t tok;
    logic   last;
  } token_rec_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code  = 8'd0;
  logic        last_char  = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [2:0]  token_kind;
  logic [2:0]  token_sub;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;
  int bytes_sent   = 0;
  int failures     = 0;
  int quiet_cycles = 0;

  scan_e       sc_mode   = SCAN_IDLE;
  logic [15:0] tok_start = 16'd0;
  logic [15:0] tok_len   = 16'd0;
  logic [15:0] next_pos  = 16'd0;
  logic [1:0]  kw_state  = KW_NONE;
  token_rec_t  step_tokens[$];
  token_rec_t  expected_tokens[$];

  source_text_tokenizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_code_i    (char_code),
    .last_char_i    (last_char),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_o   (token_kind),
    .token_sub_o    (token_sub),
    .token_start_o  (token_start),
    .token_length_o (token_length),
    .last_of_run_o  (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_dec_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_idstart(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void add_token(kind_e k, logic [2:0] sub, logic [15:0] start,
                                    logic [15:0] len);
    token_rec_t r;
    r.tok.kind  = k;
    r.tok.sub   = sub;
    r.tok.start = start;
    r.tok.len   = len;
    r.last      = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function automatic void grow_run();
    if (tok_len != 16'hFFFF) tok_len++;
  endfunction

  function automatic void open_token(scan_e m, logic [15:0] p);
    sc_mode   = m;
    tok_start = p;
    tok_len   = 16'd1;
  endfunction

  function automatic void start_fresh(logic [7:0] c, logic [15:0] p);
    sc_mode  = SCAN_IDLE;
    kw_state = KW_NONE;
    if (is_space(c)) return;
    if (c == "0") begin
      open_token(SCAN_ZERO, p);
    end else if (is_dec_char(c)) begin
      open_token(SCAN_DEC, p);
    end else if (is_idstart(c)) begin
      open_token(SCAN_IDENT, p);
      kw_state = (c == "i") ? KW_I : KW_NONE;
    end else begin
      case (c)
        ":": open_token(SCAN_COLON1, p);
        "/": open_token(SCAN_SLASH, p);
        "+": add_token(KIND_OP, SUB_PLUS, p, 16'd1);
        "-": add_token(KIND_OP, SUB_MINUS, p, 16'd1);
        "*": add_token(KIND_OP, SUB_STAR, p, 16'd1);
        "=": add_token(KIND_OP, SUB_EQUAL, p, 16'd1);
        default: add_token(KIND_ERR, SUB_NONE, p, 16'd1);
      endcase
    end
  endfunction

  function automatic void close_pending();
    case (sc_mode)
      SCAN_ZERO, SCAN_DEC: add_token(KIND_INT, BASE_DEC, tok_start, tok_len);
      SCAN_FLOAT: add_token(KIND_FLOAT, SUB_NONE, tok_start, tok_len);
      SCAN_HEX: add_token(KIND_INT, BASE_HEX, tok_start, tok_len);
      SCAN_OCT: add_token(KIND_INT, BASE_OCT, tok_start, tok_len);
      SCAN_BIN: add_token(KIND_INT, BASE_BIN, tok_start, tok_len);
      SCAN_IDENT: begin
        if (kw_state == KW_IF && tok_len == 16'd2) begin
          add_token(KIND_KW, SUB_NONE, tok_start, tok_len);
        end else begin
          add_token(KIND_ID, SUB_NONE, tok_start, tok_len);
        end
      end
      SCAN_SLASH: add_token(KIND_OP, SUB_SLASH, tok_start, 16'd1);
      SCAN_COLON1: add_token(KIND_ERR, SUB_NONE, tok_start, 16'd1);
      SCAN_COLON2: begin
        add_token(KIND_ERR, SUB_NONE, tok_start, 16'd1);
        add_token(KIND_ERR, SUB_NONE, tok_start + 16'd1, 16'd1);
      end
      default: ;
    endcase
    sc_mode  = SCAN_IDLE;
    kw_state = KW_NONE;
  endfunction

  function automatic void advance_scan(logic [7:0] c, logic [15:0] p);
    bit consumed;
    consumed = 1'b1;
    case (sc_mode)
      SCAN_ZERO: begin
        if (c == "x") begin
          sc_mode = SCAN_HEX;
          grow_run();
        end else if (c == "o") begin
          sc_mode = SCAN_OCT;
          grow_run();
        end else if (c == "b") begin
          sc_mode = SCAN_BIN;
          grow_run();
        end else if (is_dec_char(c)) begin
          sc_mode = SCAN_DEC;
          grow_run();
        end else if (c == ".") begin
          sc_mode = SCAN_FLOAT;
          grow_run();
        end else begin
          consumed = 1'b0;
        end
      end
      SCAN_DEC: begin
        if (is_dec_char(c)) begin
          grow_run();
        end else if (c == ".") begin
          sc_mode = SCAN_FLOAT;
          grow_run();
        end else begin
          consumed = 1'b0;
        end
      end
      SCAN_FLOAT: if (is_dec_char(c)) grow_run(); else consumed = 1'b0;
      SCAN_HEX: begin
        if (is_dec_char(c) || (c >= "a" && c <= "f")) grow_run();
        else consumed = 1'b0;
      end
      SCAN_OCT: if (c >= "0" && c <= "7") grow_run(); else consumed = 1'b0;
      SCAN_BIN: if (c == "0" || c == "1") grow_run(); else consumed = 1'b0;
      SCAN_IDENT: begin
        if (is_idstart(c) || is_dec_char(c)) begin
          kw_state = (kw_state == KW_I && c == "f") ? KW_IF : KW_NONE;
          grow_run();
        end else begin
          consumed = 1'b0;
        end
      end
      SCAN_SLASH: begin
        if (c == "/") begin
          add_token(KIND_OP, SUB_DSLASH, tok_start, 16'd2);
          sc_mode = SCAN_IDLE;
        end else begin
          consumed = 1'b0;
        end
      end
      SCAN_COLON1: begin
        if (c == "=") begin
          add_token(KIND_OP, SUB_ASSIGN, tok_start, 16'd2);
          sc_mode = SCAN_IDLE;
        end else if (c == ":") begin
          sc_mode = SCAN_COLON2;
          grow_run();
        end else begin
          consumed = 1'b0;
        end
      end
      SCAN_COLON2: begin
        if (c == "=") begin
          add_token(KIND_OP, SUB_DEFINE, tok_start, 16'd3);
          sc_mode = SCAN_IDLE;
        end else if (c == ":") begin
          add_token(KIND_ERR, SUB_NONE, tok_start, 16'd1);
          tok_start = tok_start + 16'd1;
        end else begin
          consumed = 1'b0;
        end
      end
      default: consumed = 1'b0;
    endcase
    if (!consumed) begin
      close_pending();
      start_fresh(c, p);
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic last_flag);
    logic [15:0] p;
    p = next_pos;
    step_tokens.delete();
    advance_scan(c, p);
    if (last_flag) begin
      close_pending();
      next_pos = 16'd0;
    end else begin
      next_pos = p + 16'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void push_string(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // One random token-shaped fragment, sometimes followed by whitespace.
  function automatic void add_fragment(ref logic [7:0] q[$]);
    string digits;
    string idchars;
    string op;
    int    n;
    digits  = "0123456789";
    idchars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(1, 4)) q.push_back(pick_char(digits));
      1: begin
        push_string(q, "0x");
        repeat ($urandom_range(0, 3)) q.push_back(pick_char("0123456789abcdefgA"));
      end
      2: begin
        push_string(q, "0o");
        repeat ($urandom_range(0, 3)) q.push_back(pick_char("012345678"));
      end
      3: begin
        push_string(q, "0b");
        repeat ($urandom_range(0, 3)) q.push_back(pick_char("0123"));
      end
      4: begin
        repeat ($urandom_range(1, 3)) q.push_back(pick_char(digits));
        q.push_back(".");
        repeat ($urandom_range(0, 3)) q.push_back(pick_char(digits));
        if ($urandom_range(0, 3) == 0) q.push_back(".");
      end
      5, 6: begin
        case ($urandom_range(0, 10))
          0: op = "::=";
          1: op = "//";
          2: op = ":=";
          3: op = "+";
          4: op = "-";
          5: op = "*";
          6: op = "/";
          7: op = "=";
          8: op = ":";
          9: op = "::";
          default: op = ":::";
        endcase
        push_string(q, op);
      end
      7: begin
        push_string(q, "if");
        if ($urandom_range(0, 1) == 0) q.push_back(pick_char(idchars));
      end
      8: begin
        q.push_back(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
        n = $urandom_range(0, 5);
        repeat (n) q.push_back(pick_char(idchars));
      end
      default: q.push_back(8'($urandom_range(0, 255)));
    endcase
    case ($urandom_range(0, 2))
      0: ;
      1: q.push_back(" ");
      default: q.push_back(8'($urandom_range(9, 13)));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last_flag);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= last_flag;
    do @(posedge clk); while (in_stall);
    tokenize_byte(c, last_flag);
    bytes_sent++;
  endtask

  task automatic send_text(input logic [7:0] text[$], input bit end_text);
    for (int i = 0; i < text.size(); i++) begin
      send_char(text[i], end_text && (i == text.size() - 1));
    end
  endtask

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= MaxReported) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic test_directed_cases();
    logic [7:0] text[$];
    push_string(text, "+-*=//if 0x9f 0o:::=7.:=/");
    send_text(text, 1'b1);
    text.delete();
    text.push_back(8'h00);
    text.push_back(8'h80);
    text.push_back(8'hFF);
    send_text(text, 1'b1);
    text.delete();
    push_string(text, "::");
    send_text(text, 1'b1);
  endtask

  task automatic test_random_texts();
    logic [7:0] text[$];
    while (bytes_sent < 210) begin
      text.delete();
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) add_fragment(text);
      end
      send_text(text, $urandom_range(0, 4) != 0);
    end
  endtask

  task automatic test_output_backpressure();
    logic [7:0] text[$];
    gaps_on = 1'b0;
    push_string(text, "+-*=::::+//=:=-*+=/:::+-0x1f if*=::=a1+-*=/");
    hold_req = 1'b1;
    send_text(text, 1'b1);
  endtask

  task automatic test_steady_stream();
    logic [7:0] text[$];
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    repeat (4) begin
      text.delete();
      repeat (5) add_fragment(text);
      send_text(text, 1'b1);
    end
  endtask

  always begin
    @(posedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall <= 1'b1;
      repeat (HoldCycles) @(posedge clk);
      out_stall <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    token_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_failure($sformatf("unexpected token kind %0d sub %0d start %0d len %0d",
                                 token_kind, token_sub, token_start, token_length));
      end else begin
        want = expected_tokens.pop_front();
        if (token_kind !== want.tok.kind || token_sub !== want.tok.sub ||
            token_start !== want.tok.start || token_length !== want.tok.len ||
            last_of_run !== want.last) begin
          report_failure($sformatf(
            "token mismatch: expected %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
            want.tok.kind, want.tok.sub, want.tok.start, want.tok.len, want.last,
            token_kind, token_sub, token_start, token_length, last_of_run));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_texts();
    test_output_backpressure();
    test_steady_stream();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
